// ===== hdl/mbet_pkg.sv =====
// Shared constants and types for the Mandelbrot escape-time block.
`timescale 1ns / 1ps

package mbet_pkg;

  // Q4.28 coordinates, Q8.56 products
  localparam int COORD_W    = 32;
  localparam int FRAC_BITS  = 28;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int COUNT_W    = 16;

  // serial multiplier digit size
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = COORD_W / DIGIT_W;
  localparam int DCNT_W     = $clog2(NUM_DIGITS);

  // |z|^2 >= 4.0 in Q8.56 means any bit at or above 2^58 is set
  localparam int ESC_BIT    = 2 * FRAC_BITS + 2;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd511;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_TEST,
    ST_HOLD
  } state_t;

endpackage

// ===== hdl/mbet_ser_mul.sv =====
// Digit-serial signed 32x32 multiplier, one 4-bit digit of b per cycle.
`timescale 1ns / 1ps

module mbet_ser_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mbet_pkg::COORD_W-1:0]  a,
  input  logic [mbet_pkg::COORD_W-1:0]  b,
  output logic                          done,
  output logic [mbet_pkg::PROD_W-1:0]   product
);

  localparam int AW = mbet_pkg::COORD_W;
  localparam int DW = mbet_pkg::DIGIT_W;
  localparam int SW = AW + DW + 1;

  logic [AW-1:0]                 a_reg;
  logic [AW-1:0]                 b_sr;
  logic [AW:0]                   acc;
  logic [AW-1:0]                 lo;
  logic [mbet_pkg::DCNT_W-1:0]   cnt;
  logic                          busy;

  logic                          last;
  logic [DW:0]                   digit;
  logic [SW-1:0]                 pp;
  logic [SW-1:0]                 sum;

  // top digit of b carries negative weight
  assign last  = (cnt == mbet_pkg::DCNT_W'(mbet_pkg::NUM_DIGITS - 1));
  assign digit = {last & b_sr[DW-1], b_sr[DW-1:0]};
  assign pp    = {{(DW + 1){a_reg[AW-1]}}, a_reg} * {{AW{digit[DW]}}, digit};
  assign sum   = {{DW{acc[AW]}}, acc} + pp;

  assign product = {acc[AW-1:0], lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      b_sr  <= b;
      acc   <= '0;
      lo    <= '0;
    end else if (busy) begin
      b_sr <= {{DW{1'b0}}, b_sr[AW-1:DW]};
      acc  <= sum[SW-1:DW];
      lo   <= {sum[DW-1:0], lo[AW-1:DW]};
    end
  end

endmodule

// ===== hdl/mandelbrot_escape_time.sv =====
// Top level of the Mandelbrot escape-time counter: control, update and result register.
`timescale 1ns / 1ps
//
// Usage:
//   Point channel (point_valid / point_stall, c_real, c_imag): one complex
//   point c in signed Q4.28. A transfer happens when point_valid is high
//   and point_stall is low; the block stalls while a point is in work.
//   Result channel (result_valid / result_stall, iteration_count): one
//   count per point, held steady while result_stall is high.
//   Config channel (cfg_valid / cfg_ready, max_iterations): cfg_ready is
//   always high; write only while the block is idle. Reset value is 511.
// Iteration:
//   Each iteration runs through the three digit-serial multipliers (x*x,
//   y*y, x*y, 4 bits per cycle), then hands over the products, then forms
//   the Q8.56 sum and difference, then does the escape test and z update.
// Reset (rst, synchronous): returns to idle, drops result_valid and loads
//   the default limit. A stalled result waits in the output register; the
//   next point is taken meanwhile and its result waits for the register.

module mandelbrot_escape_time (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                point_valid,
  output logic                                point_stall,
  input  logic signed [mbet_pkg::COORD_W-1:0] c_real,
  input  logic signed [mbet_pkg::COORD_W-1:0] c_imag,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [mbet_pkg::COUNT_W-1:0]        iteration_count,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mbet_pkg::COUNT_W-1:0]        max_iterations
);

  localparam int CW = mbet_pkg::COORD_W;
  localparam int PW = mbet_pkg::PROD_W;
  localparam int FB = mbet_pkg::FRAC_BITS;

  mbet_pkg::state_t              state, state_next;
  logic [mbet_pkg::COUNT_W-1:0]  limit;
  logic [mbet_pkg::COUNT_W-1:0]  count;
  logic [CW-1:0]                 cr, ci;
  logic [CW-1:0]                 diff_hi;
  logic                          escaped;

  logic [CW-1:0]  op_x, op_y;
  logic [CW-1:0]  new_x, new_y;
  logic [PW-1:0]  xx_p, yy_p, xy_p;
  logic [PW-1:0]  sum_sq, diff;
  logic           mul_start, mul_done;
  logic           mul_done_xx, mul_done_yy, mul_done_xy;
  logic           load_result, out_free, go_on, accept, iter_step;

  assign cfg_ready = 1'b1;
  assign accept    = point_valid & ~point_stall;

  mbet_ser_mul u_mul_xx (
    .clk(clk), .rst(rst), .start(mul_start), .a(op_x), .b(op_x),
    .done(mul_done_xx), .product(xx_p)
  );

  mbet_ser_mul u_mul_yy (
    .clk(clk), .rst(rst), .start(mul_start), .a(op_y), .b(op_y),
    .done(mul_done_yy), .product(yy_p)
  );

  mbet_ser_mul u_mul_xy (
    .clk(clk), .rst(rst), .start(mul_start), .a(op_x), .b(op_y),
    .done(mul_done_xy), .product(xy_p)
  );

  // all three run in lockstep
  assign mul_done = mul_done_xx & mul_done_yy & mul_done_xy;

  // Q8.56 sum for the radius test, difference for the real update
  assign sum_sq = xx_p + yy_p;
  assign diff   = xx_p - yy_p;

  // floor((v + c*2^28) / 2^28) keeps the low bits of v, so only upper bits add
  assign new_x = diff_hi + cr;
  assign new_y = xy_p[CW+FB-2:FB-1] + ci;

  assign go_on    = (count < limit) & ~escaped;
  assign out_free = ~result_valid | ~result_stall;

  // multiplier operands: fresh point when idle, updated z otherwise
  assign op_x = (state == mbet_pkg::ST_IDLE) ? c_real : new_x;
  assign op_y = (state == mbet_pkg::ST_IDLE) ? c_imag : new_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbet_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    mul_start   = 1'b0;
    load_result = 1'b0;
    iter_step   = 1'b0;
    point_stall = 1'b1;
    unique case (state)
      mbet_pkg::ST_IDLE: begin
        point_stall = 1'b0;
        if (point_valid) begin
          mul_start  = 1'b1;
          state_next = mbet_pkg::ST_MUL;
        end
      end
      mbet_pkg::ST_MUL: begin
        if (mul_done) begin
          state_next = mbet_pkg::ST_SUM;
        end
      end
      mbet_pkg::ST_SUM: begin
        state_next = mbet_pkg::ST_TEST;
      end
      mbet_pkg::ST_TEST: begin
        if (go_on) begin
          mul_start  = 1'b1;
          iter_step  = 1'b1;
          state_next = mbet_pkg::ST_MUL;
        end else if (out_free) begin
          load_result = 1'b1;
          state_next  = mbet_pkg::ST_IDLE;
        end else begin
          state_next = mbet_pkg::ST_HOLD;
        end
      end
      mbet_pkg::ST_HOLD: begin
        if (out_free) begin
          load_result = 1'b1;
          state_next  = mbet_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mbet_pkg::ST_IDLE;
      end
    endcase
  end

  // iteration limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= mbet_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= max_iterations;
    end
  end

  // point, counter and per-iteration results
  always_ff @(posedge clk) begin
    if (accept) begin
      cr    <= c_real;
      ci    <= c_imag;
      count <= '0;
    end else if (iter_step) begin
      count <= count + 1'b1;
    end
    if (state == mbet_pkg::ST_SUM) begin
      escaped <= |sum_sq[PW-1:mbet_pkg::ESC_BIT];
      diff_hi <= diff[CW+FB-1:FB];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      iteration_count <= count;
    end
  end

endmodule
